>>> rtl/core/alpha_region_bounding_box_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the alpha region bounding box block
// Concurrent checks with a synchronous active-low reset that masks them.
// ----------------------------------------------------------------------------
`ifndef ALPHA_REGION_BOUNDING_BOX_ASSERT_SVH
`define ALPHA_REGION_BOUNDING_BOX_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ABB_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the cycle after.
`define ABB_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/arbb_pkg.sv
// ----------------------------------------------------------------------------
// arbb_pkg
// Shared types and constants of the alpha region bounding box block.
// ----------------------------------------------------------------------------
`default_nettype none

package arbb_pkg;

  // Default largest image dimension in pixels.
  localparam int MAX_DIM_DEF = 4096;

  // Width of pixel positions in the queue and the accumulators. Holds a
  // position end of up to 65536, the largest supported image dimension.
  localparam int POS_W = 17;

  // Entries of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  localparam int REG_W     = 13;
  localparam int CH_W      = 3;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_CHANNELS      = 3'd2,
    REG_REGION_LEFT   = 3'd3,
    REG_REGION_BOTTOM = 3'd4,
    REG_REGION_RIGHT  = 3'd5,
    REG_REGION_TOP    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [REG_W-1:0] image_width;
    logic [REG_W-1:0] image_height;
    logic [CH_W-1:0]  channels;
    logic [REG_W-1:0] region_left;
    logic [REG_W-1:0] region_bottom;
    logic [REG_W-1:0] region_right;
    logic [REG_W-1:0] region_top;
  } cfg_regs_t;

  // One completed pixel as handed from the front to the back.
  typedef struct packed {
    logic             first;  // first pixel since a frame was cleared
    logic             last;   // last pixel of the frame
    logic             hit;    // nonzero alpha inside the region
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } pix_word_t;

endpackage

`default_nettype wire

>>> rtl/core/arbb_cfg.sv
// ----------------------------------------------------------------------------
// arbb_cfg
// Configuration register file written through a valid/ready port.
// ----------------------------------------------------------------------------
`default_nettype none

module arbb_cfg
  import arbb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data,
  output cfg_regs_t                 regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:   regs_nxt.image_width   = cfg_data;
        REG_IMAGE_HEIGHT:  regs_nxt.image_height  = cfg_data;
        REG_CHANNELS:      regs_nxt.channels      = cfg_data[CH_W-1:0];
        REG_REGION_LEFT:   regs_nxt.region_left   = cfg_data;
        REG_REGION_BOTTOM: regs_nxt.region_bottom = cfg_data;
        REG_REGION_RIGHT:  regs_nxt.region_right  = cfg_data;
        REG_REGION_TOP:    regs_nxt.region_top    = cfg_data;
        default:           regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.image_width   <= REG_W'(64);
      regs_r.image_height  <= REG_W'(64);
      regs_r.channels      <= CH_W'(4);
      regs_r.region_left   <= '0;
      regs_r.region_bottom <= '0;
      regs_r.region_right  <= REG_W'(64);
      regs_r.region_top    <= REG_W'(64);
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/arbb_front.sv
// ----------------------------------------------------------------------------
// arbb_front
// Counts channel, column and row of the byte stream and classifies each
// completed pixel against the clamped search region.
// ----------------------------------------------------------------------------
`default_nettype none

module arbb_front
  import arbb_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
)(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_regs_t  regs,
  input  wire logic       in_take,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_frame_start,
  output logic            push,
  output pix_word_t       push_word
);

  localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [1:0]    chan_r, chan_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic          pend_first_r, pend_first_nxt;

  logic [POS_W-1:0] width_eff, height_eff;
  logic [POS_W-1:0] left, right, bottom, top;
  logic [POS_W-1:0] col_base, row_base, col_inc, row_inc;
  logic [1:0]       chan_base, chan_last;
  logic             alpha_in_stream, nonzero, in_region, complete, end_row, end_frame;

  // Image size: zero reads as one, anything above the maximum as the maximum.
  always_comb begin
    if (regs.image_width == '0)
      width_eff = POS_W'(1);
    else if (POS_W'(regs.image_width) > POS_W'(MAX_DIM))
      width_eff = POS_W'(MAX_DIM);
    else
      width_eff = POS_W'(regs.image_width);

    if (regs.image_height == '0)
      height_eff = POS_W'(1);
    else if (POS_W'(regs.image_height) > POS_W'(MAX_DIM))
      height_eff = POS_W'(MAX_DIM);
    else
      height_eff = POS_W'(regs.image_height);
  end

  always_comb begin
    left   = (POS_W'(regs.region_left) > width_eff) ? width_eff : POS_W'(regs.region_left);
    right  = (POS_W'(regs.region_right) > width_eff) ? width_eff : POS_W'(regs.region_right);
    bottom = (POS_W'(regs.region_bottom) > height_eff) ? height_eff
                                                        : POS_W'(regs.region_bottom);
    top    = (POS_W'(regs.region_top) > height_eff) ? height_eff : POS_W'(regs.region_top);
  end

  // Channel count of zero behaves as one, five to seven as four.
  always_comb begin
    case (regs.channels)
      3'd0, 3'd1: chan_last = 2'd0;
      3'd2:       chan_last = 2'd1;
      3'd3:       chan_last = 2'd2;
      default:    chan_last = 2'd3;
    endcase
  end

  // Alpha travels in the stream only for two or four channels.
  assign alpha_in_stream = chan_last[0];

  always_comb begin
    chan_base = in_frame_start ? 2'd0 : chan_r;
    col_base  = in_frame_start ? '0 : POS_W'(col_r);
    row_base  = in_frame_start ? '0 : POS_W'(row_r);
    col_inc   = col_base + POS_W'(1);
    row_inc   = row_base + POS_W'(1);
    complete  = (chan_base >= chan_last);
    nonzero   = alpha_in_stream ? (in_data_byte != 8'd0) : 1'b1;
    in_region = (col_base >= left) && (col_base < right) &&
                (row_base >= bottom) && (row_base < top);
    end_row   = (col_inc >= width_eff);
    end_frame = end_row && (row_inc >= height_eff);
  end

  always_comb begin
    chan_nxt       = chan_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    pend_first_nxt = pend_first_r;
    if (in_take) begin
      if (complete) begin
        chan_nxt       = 2'd0;
        pend_first_nxt = end_frame;
        if (end_row) begin
          col_nxt = '0;
          row_nxt = end_frame ? '0 : CW'(row_inc);
        end else begin
          col_nxt = CW'(col_inc);
          row_nxt = CW'(row_base);
        end
      end else begin
        chan_nxt       = chan_base + 2'd1;
        col_nxt        = CW'(col_base);
        row_nxt        = CW'(row_base);
        pend_first_nxt = pend_first_r | in_frame_start;
      end
    end
  end

  assign push            = in_take && complete;
  assign push_word.first = pend_first_r | in_frame_start;
  assign push_word.last  = end_frame;
  assign push_word.hit   = nonzero && in_region;
  assign push_word.col   = col_base;
  assign push_word.row   = row_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r       <= '0;
      col_r        <= '0;
      row_r        <= '0;
      pend_first_r <= 1'b1;
    end else begin
      chan_r       <= chan_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      pend_first_r <= pend_first_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/arbb_queue.sv
// ----------------------------------------------------------------------------
// arbb_queue
// Short pixel queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module arbb_queue
  import arbb_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire pix_word_t push_word,
  input  wire logic      pop,
  output logic           head_valid,
  output pix_word_t      head_word,
  output logic           full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  pix_word_t         slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign head_valid = (count_r != '0);
  assign full       = (count_r == NW'(DEPTH));
  assign head_word  = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push)
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (do_pop)
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (do_push && !do_pop)
      count_nxt = count_r + NW'(1);
    else if (do_pop && !do_push)
      count_nxt = count_r - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/arbb_back.sv
// ----------------------------------------------------------------------------
// arbb_back
// Accumulates the bounding box of hit pixels and holds the frame result in
// an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "alpha_region_bounding_box_assert.svh"

module arbb_back
  import arbb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         head_valid,
  input  wire pix_word_t    head_word,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic              out_found,
  output logic [REG_W-1:0]  out_box_left,
  output logic [REG_W-1:0]  out_box_bottom,
  output logic [REG_W-1:0]  out_box_right,
  output logic [REG_W-1:0]  out_box_top
);

  logic             found_r;
  logic [POS_W-1:0] min_col_r, min_row_r, max_col_r, max_row_r;
  logic             found_nxt;
  logic [POS_W-1:0] min_col_nxt, min_row_nxt, max_col_nxt, max_row_nxt;
  logic [POS_W-1:0] col_end, row_end;
  logic             base_found, take;

  logic             out_valid_r;
  logic             out_found_r;
  logic [REG_W-1:0] out_left_r, out_bottom_r, out_right_r, out_top_r;

  // A frame end may only move on when the output register is free or drains.
  assign take = head_valid && (!head_word.last || !out_valid_r || !out_stall);
  assign pop  = take;

  always_comb begin
    col_end     = head_word.col + POS_W'(1);
    row_end     = head_word.row + POS_W'(1);
    base_found  = head_word.first ? 1'b0 : found_r;
    found_nxt   = base_found;
    min_col_nxt = min_col_r;
    min_row_nxt = min_row_r;
    max_col_nxt = max_col_r;
    max_row_nxt = max_row_r;
    if (head_word.hit) begin
      found_nxt = 1'b1;
      if (!base_found) begin
        min_col_nxt = head_word.col;
        min_row_nxt = head_word.row;
        max_col_nxt = col_end;
        max_row_nxt = row_end;
      end else begin
        if (head_word.col < min_col_r) min_col_nxt = head_word.col;
        if (head_word.row < min_row_r) min_row_nxt = head_word.row;
        if (col_end > max_col_r)       max_col_nxt = col_end;
        if (row_end > max_row_r)       max_row_nxt = row_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      min_col_r <= min_col_nxt;
      min_row_r <= min_row_nxt;
      max_col_r <= max_col_nxt;
      max_row_r <= max_row_nxt;
    end
    if (take && head_word.last) begin
      out_found_r  <= found_nxt;
      out_left_r   <= found_nxt ? REG_W'(min_col_nxt) : '0;
      out_bottom_r <= found_nxt ? REG_W'(min_row_nxt) : '0;
      out_right_r  <= found_nxt ? REG_W'(max_col_nxt) : '0;
      out_top_r    <= found_nxt ? REG_W'(max_row_nxt) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        found_r <= head_word.last ? 1'b0 : found_nxt;
      end
      if (take && head_word.last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_box_left   = out_left_r;
  assign out_box_bottom = out_bottom_r;
  assign out_box_right  = out_right_r;
  assign out_box_top    = out_top_r;

  `ABB_ASSERT_NEXT(a_clear_after_end, clk, rst_n, take && head_word.last, !found_r,
                   "bounds survived a frame end")
  `ABB_ASSERT_IMP(a_box_ordered, clk, rst_n, found_r,
                  (min_col_r < max_col_r) && (min_row_r < max_row_r),
                  "box ends not beyond box starts")
  `ABB_ASSERT_IMP(a_result_from_end, clk, rst_n, $rose(out_valid_r),
                  $past(take && head_word.last), "result appeared without a frame end")
  `ABB_ASSERT_NEXT(a_result_kept, clk, rst_n, out_valid_r && out_stall,
                   out_valid_r && $stable(out_left_r) && $stable(out_top_r),
                   "stalled result was lost")

endmodule

`default_nettype wire

>>> rtl/core/alpha_region_bounding_box.sv
// ----------------------------------------------------------------------------
// alpha_region_bounding_box
// Bounding box of nonzero-alpha pixels inside a region of a raster byte stream.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                Word
//   in_      sink       in_valid / in_stall      data_byte, frame_start
//   out_     source     out_valid / out_stall    found, box_left/bottom/right/top
//   cfg_     sink       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One input word is taken every cycle while in_stall is low. The frame's
// last byte writes its pixel into the queue; the back then moves that pixel
// through the accumulator into the output register once every pixel queued
// ahead of it has been taken and the output register is free or drains.
// Reset is synchronous on rst_n low; it restores the register defaults
// (64 x 64 image, four channels, region covering the image) and clears
// counters, queue and output. in_stall rises only when the four-entry pixel
// queue is full, which happens only while out_stall holds a result and
// another frame end waits behind it. cfg_ready is always high.
//
// The front counts channel, column and row and classifies every finished
// pixel against the clamped region; the back keeps the least and greatest
// hit positions and loads the result at the frame end. The pixel queue lets
// the front keep taking bytes while the back waits on a stalled result.
// A frame_start word clears counters at once; the first pixel pushed after
// it carries a mark that makes the back restart its bounds.
// MAX_DIM may range from 16 to 65536.
//
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_region_bounding_box
  import arbb_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
)(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_frame_start,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_found,
  output logic [REG_W-1:0]          out_box_left,
  output logic [REG_W-1:0]          out_box_bottom,
  output logic [REG_W-1:0]          out_box_right,
  output logic [REG_W-1:0]          out_box_top,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data
);

  cfg_regs_t regs;
  pix_word_t push_word;
  pix_word_t head_word;
  logic      push, pop, head_valid, q_full, in_take;

  // The stall depends only on queue fill, never on in_valid.
  assign in_stall = q_full;
  assign in_take  = in_valid && !in_stall;

  arbb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  arbb_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .regs           (regs),
    .in_take        (in_take),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .push           (push),
    .push_word      (push_word)
  );

  arbb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_word  (push_word),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word),
    .full       (q_full)
  );

  arbb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_word      (head_word),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_box_left   (out_box_left),
    .out_box_bottom (out_box_bottom),
    .out_box_right  (out_box_right),
    .out_box_top    (out_box_top)
  );

endmodule

`default_nettype wire
